@@ sv/dipc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dipc_pkg: shared types and constants for the integer power chain
// Register codes, FPU and controller states, command/status bundles and
// the addition-chain program table, one program per exponent magnitude.
// ----------------------------------------------------------------------------
package dipc_pkg;

	localparam int unsigned MAX_POWER = 40;

	localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
	localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;

	// register file slots; ONE reads as constant 1.0
	typedef enum logic [2:0] {
		R_X, R_A, R_B, R_C, R_D, R_E, R_T, R_ONE
	} reg_t;

	typedef enum logic {
		FOP_MUL,
		FOP_RCP
	} fpu_op_t;

	typedef enum logic [2:0] {
		FPU_IDLE, FPU_MUL, FPU_NORM, FPU_DIV, FPU_ROUND
	} fpu_state_t;

	typedef enum logic [2:0] {
		C_IDLE, C_READ, C_GO, C_WAIT, C_OUT
	} ctl_state_t;

	// one multiply of the chain: d = a * b
	typedef struct packed {
		logic v;
		reg_t d;
		reg_t a;
		reg_t b;
	} op_t;

	typedef struct packed {
		logic [3:0]     len;
		op_t [7:0]      ops;
	} prog_t;

	typedef struct packed {
		logic    load_in;
		reg_t    rd_a;
		reg_t    rd_b;
		logic    fpu_start;
		fpu_op_t fpu_op;
		logic    wr_en;
		reg_t    wr_dst;
		logic    out_load;
		logic    out_zero;
	} cmd_t;

	typedef struct packed {
		logic fpu_done;
		logic out_free;
	} sts_t;

	localparam op_t NOP_OP = '{v: 1'b0, d: R_X, a: R_X, b: R_X};

	function automatic op_t mk_op(input reg_t d, input reg_t a, input reg_t b);
		mk_op = '{v: 1'b1, d: d, a: a, b: b};
	endfunction

	function automatic prog_t mk_prog(input op_t o0, input op_t o1 = NOP_OP,
			input op_t o2 = NOP_OP, input op_t o3 = NOP_OP, input op_t o4 = NOP_OP,
			input op_t o5 = NOP_OP, input op_t o6 = NOP_OP, input op_t o7 = NOP_OP);
		prog_t p;
		p.ops[0] = o0;
		p.ops[1] = o1;
		p.ops[2] = o2;
		p.ops[3] = o3;
		p.ops[4] = o4;
		p.ops[5] = o5;
		p.ops[6] = o6;
		p.ops[7] = o7;
		p.len = '0;
		for (int i = 0; i < 8; i++) begin
			p.len = p.len + 4'(p.ops[i].v);
		end
		mk_prog = p;
	endfunction

	// chain per magnitude; products accumulate in T, left to right
	function automatic prog_t chain_prog(input logic [5:0] mag);
		op_t axx, baa, cbb, dcc, aax;
		axx = mk_op(R_A, R_X, R_X);
		baa = mk_op(R_B, R_A, R_A);
		cbb = mk_op(R_C, R_B, R_B);
		dcc = mk_op(R_D, R_C, R_C);
		aax = mk_op(R_A, R_A, R_X);
		case (mag)
			6'd1: chain_prog = mk_prog(mk_op(R_T, R_X, R_ONE));
			6'd2: chain_prog = mk_prog(mk_op(R_T, R_X, R_X));
			6'd3: chain_prog = mk_prog(mk_op(R_T, R_X, R_X), mk_op(R_T, R_T, R_X));
			6'd4: chain_prog = mk_prog(axx, mk_op(R_T, R_A, R_A));
			6'd5: chain_prog = mk_prog(axx, mk_op(R_T, R_A, R_A), mk_op(R_T, R_T, R_X));
			6'd6: chain_prog = mk_prog(axx, aax, mk_op(R_T, R_A, R_A));
			6'd7: chain_prog = mk_prog(axx, aax, mk_op(R_T, R_A, R_A),
					mk_op(R_T, R_T, R_X));
			6'd8: chain_prog = mk_prog(axx, baa, mk_op(R_T, R_B, R_B));
			6'd9: chain_prog = mk_prog(axx, baa, mk_op(R_T, R_B, R_B),
					mk_op(R_T, R_T, R_X));
			6'd10: chain_prog = mk_prog(axx, baa, mk_op(R_T, R_B, R_B),
					mk_op(R_T, R_T, R_A));
			6'd11: chain_prog = mk_prog(axx, baa, mk_op(R_T, R_B, R_B),
					mk_op(R_T, R_T, R_A), mk_op(R_T, R_T, R_X));
			6'd12: chain_prog = mk_prog(axx, baa, mk_op(R_T, R_B, R_B),
					mk_op(R_T, R_T, R_B));
			6'd13: chain_prog = mk_prog(axx, baa, mk_op(R_T, R_B, R_B),
					mk_op(R_T, R_T, R_B), mk_op(R_T, R_T, R_X));
			6'd14: chain_prog = mk_prog(axx, baa, mk_op(R_T, R_B, R_B),
					mk_op(R_T, R_T, R_B), mk_op(R_T, R_T, R_A));
			6'd15: chain_prog = mk_prog(axx, aax, baa, mk_op(R_T, R_B, R_B),
					mk_op(R_T, R_T, R_A));
			6'd16: chain_prog = mk_prog(axx, baa, cbb, mk_op(R_T, R_C, R_C));
			6'd17: chain_prog = mk_prog(axx, baa, cbb, mk_op(R_T, R_C, R_C),
					mk_op(R_T, R_T, R_X));
			6'd18: chain_prog = mk_prog(axx, baa, cbb, mk_op(R_T, R_C, R_C),
					mk_op(R_T, R_T, R_A));
			6'd19: chain_prog = mk_prog(axx, baa, cbb, mk_op(R_T, R_C, R_C),
					mk_op(R_T, R_T, R_A), mk_op(R_T, R_T, R_X));
			6'd20: chain_prog = mk_prog(axx, baa, cbb, mk_op(R_T, R_C, R_C),
					mk_op(R_T, R_T, R_B));
			6'd21: chain_prog = mk_prog(axx, aax, baa, mk_op(R_T, R_B, R_B),
					mk_op(R_T, R_T, R_B), mk_op(R_T, R_T, R_A));
			6'd22: chain_prog = mk_prog(axx, baa, cbb, mk_op(R_C, R_C, R_A),
					mk_op(R_C, R_C, R_X), mk_op(R_T, R_C, R_C));
			6'd23: chain_prog = mk_prog(axx, mk_op(R_B, R_X, R_A), mk_op(R_C, R_A, R_B),
					mk_op(R_D, R_C, R_C), mk_op(R_T, R_D, R_D), mk_op(R_T, R_T, R_B));
			6'd24: chain_prog = mk_prog(axx, baa, cbb, mk_op(R_C, R_C, R_B),
					mk_op(R_T, R_C, R_C));
			6'd25: chain_prog = mk_prog(axx, baa, cbb, mk_op(R_T, R_C, R_C),
					mk_op(R_T, R_T, R_C), mk_op(R_T, R_T, R_X));
			6'd26: chain_prog = mk_prog(axx, baa, cbb, mk_op(R_C, R_C, R_B),
					mk_op(R_C, R_C, R_X), mk_op(R_T, R_C, R_C));
			6'd27: chain_prog = mk_prog(axx, baa, cbb, mk_op(R_C, R_C, R_X),
					mk_op(R_T, R_C, R_C), mk_op(R_T, R_T, R_C));
			6'd28: chain_prog = mk_prog(axx, baa, cbb, mk_op(R_C, R_C, R_B),
					mk_op(R_C, R_C, R_A), mk_op(R_T, R_C, R_C));
			6'd29: chain_prog = mk_prog(axx, baa, cbb, mk_op(R_T, R_B, R_C),
					mk_op(R_T, R_T, R_C), mk_op(R_T, R_T, R_C), mk_op(R_T, R_T, R_X));
			6'd30: chain_prog = mk_prog(axx, aax, baa, cbb, mk_op(R_C, R_C, R_A),
					mk_op(R_T, R_C, R_C));
			6'd31: chain_prog = mk_prog(axx, aax, baa, cbb, mk_op(R_C, R_C, R_A),
					mk_op(R_T, R_C, R_C), mk_op(R_T, R_T, R_X));
			6'd32: chain_prog = mk_prog(axx, baa, cbb, dcc, mk_op(R_T, R_D, R_D));
			6'd33: chain_prog = mk_prog(axx, baa, cbb, dcc, mk_op(R_T, R_X, R_D),
					mk_op(R_T, R_T, R_D));
			6'd34: chain_prog = mk_prog(axx, baa, cbb, dcc, mk_op(R_D, R_D, R_X),
					mk_op(R_T, R_D, R_D));
			6'd35: chain_prog = mk_prog(axx, baa, cbb, mk_op(R_C, R_C, R_X),
					mk_op(R_D, R_B, R_C), mk_op(R_T, R_D, R_D), mk_op(R_T, R_T, R_C));
			6'd36: chain_prog = mk_prog(axx, baa, cbb, dcc, mk_op(R_D, R_D, R_A),
					mk_op(R_T, R_D, R_D));
			6'd37: chain_prog = mk_prog(axx, baa, cbb, dcc, mk_op(R_D, R_D, R_A),
					mk_op(R_T, R_X, R_D), mk_op(R_T, R_T, R_D));
			6'd38: chain_prog = mk_prog(axx, baa, cbb, dcc, mk_op(R_D, R_D, R_A),
					mk_op(R_D, R_D, R_X), mk_op(R_T, R_D, R_D));
			6'd39: chain_prog = mk_prog(axx, mk_op(R_B, R_X, R_A), cbb, dcc,
					mk_op(R_T, R_D, R_D), mk_op(R_T, R_T, R_D), mk_op(R_T, R_T, R_B));
			6'd40: chain_prog = mk_prog(axx, baa, cbb, mk_op(R_E, R_C, R_C),
					mk_op(R_E, R_E, R_B), mk_op(R_T, R_E, R_E));
			// zero exponent: 1.0 * 1.0
			default: chain_prog = mk_prog(mk_op(R_T, R_ONE, R_ONE));
		endcase
	endfunction

endpackage

@@ sv/dipc_fpu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dipc_fpu: multi-cycle binary64 multiply and reciprocal
// Multiply: four 32x32 partial products, one a cycle. Reciprocal: restoring
// division one quotient bit a cycle. Both share normalize and RNE rounding
// with subnormal results.
// ----------------------------------------------------------------------------
module dipc_fpu import dipc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  fpu_op_t     op,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] res
);

	localparam logic signed [13:0] EXP_BIAS = 14'sd1023;
	localparam logic signed [13:0] EXP_SUB  = -14'sd1022;

	fpu_state_t         state_q, state_d;
	logic               done_q, done_d;
	logic [105:0]       sig_q, sig_d;
	logic signed [13:0] exp_q, exp_d;
	logic               sign_q, sign_d;
	logic               rcp_q, rcp_d;
	logic               phase_q, phase_d;
	logic [5:0]         cnt_q, cnt_d;
	logic [52:0]        ma_q, ma_d, mb_q, mb_d;
	logic [63:0]        pp_q, pp_d;
	logic [1:0]         ppsh_q, ppsh_d;
	logic [52:0]        div_q, div_d;
	logic [53:0]        rem_q, rem_d;
	logic [54:0]        quo_q, quo_d;
	logic [63:0]        res_q, res_d;

	// operand unpack
	logic               a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
	logic [52:0]        a_man, b_man;
	logic signed [13:0] a_exp, b_exp;

	always_comb begin
		a_nan  = (&a[62:52]) && (|a[51:0]);
		a_inf  = (&a[62:52]) && !(|a[51:0]);
		a_zero = (a[62:0] == '0);
		b_nan  = (&b[62:52]) && (|b[51:0]);
		b_inf  = (&b[62:52]) && !(|b[51:0]);
		b_zero = (b[62:0] == '0);
		a_man  = {|a[62:52], a[51:0]};
		b_man  = {|b[62:52], b[51:0]};
		a_exp  = (a[62:52] == '0) ? EXP_SUB : (signed'({3'b000, a[62:52]}) - EXP_BIAS);
		b_exp  = (b[62:52] == '0) ? EXP_SUB : (signed'({3'b000, b[62:52]}) - EXP_BIAS);
	end

	// partial product operand select
	logic [31:0]  pp_x, pp_y;
	logic [105:0] pp_ext;

	always_comb begin
		case (cnt_q[2:0])
			3'd0: begin pp_x = ma_q[31:0]; pp_y = mb_q[31:0]; end
			3'd1: begin pp_x = ma_q[31:0]; pp_y = {11'b0, mb_q[52:32]}; end
			3'd2: begin pp_x = {11'b0, ma_q[52:32]}; pp_y = mb_q[31:0]; end
			3'd3: begin pp_x = {11'b0, ma_q[52:32]}; pp_y = {11'b0, mb_q[52:32]}; end
			default: begin pp_x = '0; pp_y = '0; end
		endcase
		case (ppsh_q)
			2'd0:    pp_ext = {42'b0, pp_q};
			2'd1:    pp_ext = {10'b0, pp_q, 32'b0};
			default: pp_ext = {pp_q[41:0], 64'b0};
		endcase
	end

	// division step
	logic        div_ge;
	logic [53:0] div_rd;

	always_comb begin
		div_ge = (rem_q >= {1'b0, div_q});
		div_rd = div_ge ? (rem_q - {1'b0, div_q}) : rem_q;
	end

	// rounding, with right shift for subnormal results
	logic signed [13:0] rb_be, rb_sh_full, rb_e;
	logic [5:0]         rb_sh;
	logic               rb_lost, rb_norm, rb_inc;
	logic [105:0]       rb_sig;
	logic [53:0]        rb_mr;
	logic [63:0]        rb_res;

	always_comb begin
		rb_be      = exp_q + EXP_BIAS;
		rb_sh_full = 14'sd1 - rb_be;
		rb_sh      = (rb_sh_full > 14'sd63) ? 6'd63 : rb_sh_full[5:0];
		rb_lost    = |(sig_q & ~({106{1'b1}} << rb_sh));
		rb_norm    = (rb_be > 14'sd0);
		rb_sig     = rb_norm ? sig_q : ((sig_q >> rb_sh) | {105'b0, rb_lost});
		rb_inc     = rb_sig[52] & ((|rb_sig[51:0]) | rb_sig[53]);
		rb_mr      = {1'b0, rb_sig[105:53]} + {53'b0, rb_inc};
		rb_e       = rb_be + signed'({13'b0, rb_mr[53]});
		if (!rb_norm) begin
			rb_res = {sign_q, 10'b0, rb_mr[52], rb_mr[51:0]};
		end else if (rb_e >= 14'sd2047) begin
			rb_res = {sign_q, 11'h7FF, 52'b0};
		end else begin
			rb_res = {sign_q, rb_e[10:0], rb_mr[53] ? rb_mr[52:1] : rb_mr[51:0]};
		end
	end

	// next-state and datapath update
	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		sig_d   = sig_q;
		exp_d   = exp_q;
		sign_d  = sign_q;
		rcp_d   = rcp_q;
		phase_d = phase_q;
		cnt_d   = cnt_q;
		ma_d    = ma_q;
		mb_d    = mb_q;
		pp_d    = pp_q;
		ppsh_d  = ppsh_q;
		div_d   = div_q;
		rem_d   = rem_q;
		quo_d   = quo_q;
		res_d   = res_q;
		case (state_q)
			FPU_IDLE: begin
				if (start) begin
					cnt_d   = '0;
					phase_d = 1'b0;
					rcp_d   = (op == FOP_RCP);
					if (op == FOP_MUL) begin
						sign_d = a[63] ^ b[63];
						if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
							res_d  = CANON_NAN;
							done_d = 1'b1;
						end else if (a_inf || b_inf) begin
							res_d  = {a[63] ^ b[63], 11'h7FF, 52'b0};
							done_d = 1'b1;
						end else if (a_zero || b_zero) begin
							res_d  = {a[63] ^ b[63], 63'b0};
							done_d = 1'b1;
						end else begin
							ma_d    = a_man;
							mb_d    = b_man;
							exp_d   = a_exp + b_exp + 14'sd1;
							sig_d   = '0;
							state_d = FPU_MUL;
						end
					end else begin
						sign_d = a[63];
						if (a_nan) begin
							res_d  = CANON_NAN;
							done_d = 1'b1;
						end else if (a_inf) begin
							res_d  = {a[63], 63'b0};
							done_d = 1'b1;
						end else if (a_zero) begin
							res_d  = {a[63], 11'h7FF, 52'b0};
							done_d = 1'b1;
						end else begin
							sig_d   = {a_man, 53'b0};
							exp_d   = a_exp;
							state_d = FPU_NORM;
						end
					end
				end
			end
			FPU_MUL: begin
				// product of this cycle registered, previous one accumulated
				pp_d   = {32'b0, pp_x} * {32'b0, pp_y};
				ppsh_d = (cnt_q == 6'd0) ? 2'd0 : ((cnt_q == 6'd3) ? 2'd2 : 2'd1);
				if (cnt_q != 6'd0) begin
					sig_d = sig_q + pp_ext;
				end
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'd4) begin
					state_d = FPU_NORM;
				end
			end
			FPU_NORM: begin
				if (sig_q[105]) begin
					if (rcp_q && !phase_q) begin
						div_d   = sig_q[105:53];
						rem_d   = 54'h1 << 52;
						quo_d   = '0;
						cnt_d   = '0;
						state_d = FPU_DIV;
					end else begin
						state_d = FPU_ROUND;
					end
				end else if (sig_q[105:98] == '0) begin
					sig_d = sig_q << 8;
					exp_d = exp_q - 14'sd8;
				end else begin
					sig_d = sig_q << 1;
					exp_d = exp_q - 14'sd1;
				end
			end
			FPU_DIV: begin
				quo_d = {quo_q[53:0], div_ge};
				rem_d = {div_rd[52:0], 1'b0};
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'd54) begin
					sig_d   = {quo_q[53:0], div_ge, 50'b0, |div_rd};
					exp_d   = -exp_q;
					phase_d = 1'b1;
					state_d = FPU_NORM;
				end
			end
			FPU_ROUND: begin
				res_d   = rb_res;
				done_d  = 1'b1;
				state_d = FPU_IDLE;
			end
			default: state_d = FPU_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FPU_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		sig_q   <= sig_d;
		exp_q   <= exp_d;
		sign_q  <= sign_d;
		rcp_q   <= rcp_d;
		phase_q <= phase_d;
		cnt_q   <= cnt_d;
		ma_q    <= ma_d;
		mb_q    <= mb_d;
		pp_q    <= pp_d;
		ppsh_q  <= ppsh_d;
		div_q   <= div_d;
		rem_q   <= rem_d;
		quo_q   <= quo_d;
		res_q   <= res_d;
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

@@ sv/dipc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dipc_datapath: register file, FPU and output register
// Eight-slot register file with registered reads (slot ONE reads 1.0),
// written by the input load or by FPU results.
// ----------------------------------------------------------------------------
module dipc_datapath import dipc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [63:0] base_bits,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,
	output logic        m_tuser
);

	logic [63:0] rf_q [0:7];
	logic [63:0] rd_a_q, rd_b_q;
	logic        fpu_done;
	logic [63:0] fpu_res;
	logic        ov_q;
	logic [63:0] out_q;
	logic        oor_q;

	// register file
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			rf_q[R_X] <= base_bits;
		end else if (cmd.wr_en) begin
			rf_q[cmd.wr_dst] <= fpu_res;
		end
		rd_a_q <= (cmd.rd_a == R_ONE) ? ONE_BITS : rf_q[cmd.rd_a];
		rd_b_q <= (cmd.rd_b == R_ONE) ? ONE_BITS : rf_q[cmd.rd_b];
	end

	dipc_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.fpu_start),
		.op     (cmd.fpu_op),
		.a      (rd_a_q),
		.b      (rd_b_q),
		.done   (fpu_done),
		.res    (fpu_res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.out_load) begin
			ov_q <= 1'b1;
		end else if (m_tready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= cmd.out_zero ? '0 : fpu_res;
			oor_q <= cmd.out_zero;
		end
	end

	assign sts.fpu_done = fpu_done;
	assign sts.out_free = !ov_q || m_tready;
	assign m_tvalid     = ov_q;
	assign m_tdata      = out_q;
	assign m_tuser      = oor_q;

endmodule

@@ sv/dipc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dipc_ctrl: sequencer for the reciprocal and the multiply chain
// Steps through the chain program of the exponent magnitude, one FPU
// operation at a time, and hands the final product to the output register.
// ----------------------------------------------------------------------------
module dipc_ctrl import dipc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] power,
	output cmd_t       cmd,
	input  sts_t       sts
);

	ctl_state_t state_q, state_d;
	logic [5:0] mag_q;
	logic       rcp_q;
	logic       oor_q;
	logic [2:0] step_q;

	logic [7:0] in_mag;
	logic       in_oor;
	logic       accept;
	prog_t      prog;
	op_t        cur;
	logic       last;

	always_comb begin
		in_mag = power[7] ? (8'd0 - power) : power;
		in_oor = (in_mag > 8'(MAX_POWER));
		accept = (state_q == C_IDLE) && s_tvalid;
		prog   = chain_prog(mag_q);
		cur    = prog.ops[step_q];
		last   = ((4'(step_q) + 4'd1) == prog.len);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			C_IDLE: begin
				if (s_tvalid) begin
					state_d = in_oor ? C_OUT : C_READ;
				end
			end
			C_READ: state_d = C_GO;
			C_GO:   state_d = C_WAIT;
			C_WAIT: begin
				if (sts.fpu_done) begin
					state_d = (rcp_q || !last) ? C_READ : C_OUT;
				end
			end
			C_OUT: begin
				if (sts.out_free) begin
					state_d = C_IDLE;
				end
			end
			default: state_d = C_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready      = 1'b0;
		cmd           = '0;
		cmd.rd_a      = rcp_q ? R_X : cur.a;
		cmd.rd_b      = rcp_q ? R_X : cur.b;
		cmd.fpu_op    = rcp_q ? FOP_RCP : FOP_MUL;
		cmd.wr_dst    = rcp_q ? R_X : cur.d;
		cmd.out_zero  = oor_q;
		case (state_q)
			C_IDLE: begin
				s_tready    = 1'b1;
				cmd.load_in = s_tvalid;
			end
			C_GO:    cmd.fpu_start = 1'b1;
			C_WAIT:  cmd.wr_en     = sts.fpu_done;
			C_OUT:   cmd.out_load  = sts.out_free;
			default: cmd.load_in   = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			mag_q   <= '0;
			rcp_q   <= 1'b0;
			oor_q   <= 1'b0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				mag_q  <= in_mag[5:0];
				oor_q  <= in_oor;
				rcp_q  <= power[7] && !in_oor;
				step_q <= '0;
			end else if (state_q == C_WAIT && sts.fpu_done) begin
				if (rcp_q) begin
					rcp_q <= 1'b0;
				end else if (!last) begin
					step_q <= step_q + 3'd1;
				end
			end
		end
	end

endmodule

@@ sv/double_integer_power_chain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_integer_power_chain: binary64 base raised to a signed 8-bit power
// Channel  Dir  Bits                        Contents
// s_*      in   tdata[63:0], tdata[71:64]   base_bits, power
// m_*      out  tdata[63:0], tuser          result_bits, overrange
//
// One item at a time. Each multiply of the chain runs on the shared FPU as
// read, start, 4 partial products of 32x32 plus accumulate, normalize,
// round, done; an item with magnitude n runs ops(n) multiplies, up to 7.
// A negative power adds the reciprocal first (one quotient bit a cycle).
// Subnormal operands add normalize steps. Out-of-range items skip the
// chain and go straight to the output. Reset is asynchronous, active low.
// A stalled output holds the sequencer.
// ----------------------------------------------------------------------------
module double_integer_power_chain import dipc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // base_bits [63:0], power [71:64]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // result_bits [63:0]
	output logic        m_tuser    // overrange [0]
);

	cmd_t cmd;
	sts_t sts;

	dipc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.power    (s_tdata[71:64]),
		.cmd      (cmd),
		.sts      (sts)
	);

	dipc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.base_bits (s_tdata[63:0]),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

@@ verif/double_integer_power_chain_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_integer_power_chain_tb: self-checking bench for the integer power chain
// Drives base/power items on the input stream and compares every output item
// with a predictor that repeats the same multiply chains in host binary64
// arithmetic, which rounds to nearest even and keeps subnormals. Both stream
// sides idle at random. The output side stalls once for a long stretch.
// ----------------------------------------------------------------------------
module double_integer_power_chain_tb import dipc_pkg::*;;

	localparam int N_RANDOM  = 1500;
	localparam int HOLD_OFF  = 400;
	localparam int WDOG_MAX  = 5000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;   // base_bits [63:0], power [71:64]
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // result_bits [63:0]
	logic        m_tuser;   // overrange [0]

	typedef struct {
		logic [63:0] result_bits;
		logic        overrange;
	} power_result_t;

	// chain of double multiplies, left to right, per exponent magnitude
	function automatic real chain_power(input real x, input int n);
		real a, b, c, d, e;
		case (n)
			1: return x;
			2: return x * x;
			3: return x * x * x;
			4: begin a = x * x; return a * a; end
			5: begin a = x * x; return a * a * x; end
			6: begin a = x * x * x; return a * a; end
			7: begin a = x * x * x; return a * a * x; end
			8: begin a = x * x; b = a * a; return b * b; end
			9: begin a = x * x; b = a * a; return b * b * x; end
			10: begin a = x * x; b = a * a; return b * b * a; end
			11: begin a = x * x; b = a * a; return b * b * a * x; end
			12: begin a = x * x; b = a * a; return b * b * b; end
			13: begin a = x * x; b = a * a; return b * b * b * x; end
			14: begin a = x * x; b = a * a; return b * b * b * a; end
			15: begin a = x * x * x; b = a * a; return b * b * a; end
			16: begin a = x * x; b = a * a; c = b * b; return c * c; end
			17: begin a = x * x; b = a * a; c = b * b; return c * c * x; end
			18: begin a = x * x; b = a * a; c = b * b; return c * c * a; end
			19: begin a = x * x; b = a * a; c = b * b; return c * c * a * x; end
			20: begin a = x * x; b = a * a; c = b * b; return c * c * b; end
			21: begin a = x * x * x; b = a * a; return b * b * b * a; end
			22: begin a = x * x; b = a * a; c = b * b * a * x; return c * c; end
			23: begin a = x * x; b = x * a; c = a * b; d = c * c; return d * d * b; end
			24: begin a = x * x; b = a * a; c = b * b * b; return c * c; end
			25: begin a = x * x; b = a * a; c = b * b; return c * c * c * x; end
			26: begin a = x * x; b = a * a; c = b * b * b * x; return c * c; end
			27: begin a = x * x; b = a * a; c = b * b * x; return c * c * c; end
			28: begin a = x * x; b = a * a; c = b * b * b * a; return c * c; end
			29: begin a = x * x; b = a * a; c = b * b; return b * c * c * c * x; end
			30: begin a = x * x * x; b = a * a; c = b * b * a; return c * c; end
			31: begin a = x * x * x; b = a * a; c = b * b * a; return c * c * x; end
			32: begin a = x * x; b = a * a; c = b * b; d = c * c; return d * d; end
			33: begin a = x * x; b = a * a; c = b * b; d = c * c; return x * d * d; end
			34: begin a = x * x; b = a * a; c = b * b; d = c * c * x; return d * d; end
			35: begin a = x * x; b = a * a; c = b * b * x; d = b * c; return d * d * c; end
			36: begin a = x * x; b = a * a; c = b * b; d = c * c * a; return d * d; end
			37: begin a = x * x; b = a * a; c = b * b; d = c * c * a; return x * d * d; end
			38: begin a = x * x; b = a * a; c = b * b; d = c * c * a * x; return d * d; end
			39: begin a = x * x; b = x * a; c = b * b; d = c * c; return d * d * d * b; end
			40: begin a = x * x; b = a * a; c = b * b; e = c * c * b; return e * e; end
			default: return 1.0;
		endcase
	endfunction

	function automatic power_result_t predict_power(input logic [63:0] base,
			input logic signed [7:0] pw);
		power_result_t r;
		int  mag;
		real x;
		mag = (pw < 0) ? -int'(pw) : int'(pw);
		r.overrange = 1'b0;
		if (mag > MAX_POWER) begin
			r.result_bits = '0;
			r.overrange   = 1'b1;
		end else if (mag == 0) begin
			r.result_bits = ONE_BITS;
		end else begin
			if (pw < 0) begin
				// reciprocal of a signed zero is a signed infinity
				if (base[62:0] == '0)
					x = $bitstoreal(base[63] ? 64'hFFF0_0000_0000_0000
						: 64'h7FF0_0000_0000_0000);
				else
					x = 1.0 / $bitstoreal(base);
			end else begin
				x = $bitstoreal(base);
			end
			r.result_bits = $realtobits(chain_power(x, mag));
			if (r.result_bits[62:52] == '1 && r.result_bits[51:0] != '0)
				r.result_bits = CANON_NAN;
		end
		return r;
	endfunction

	// expected results in order of acceptance
	class power_scoreboard;
		power_result_t pending[$];
		int            errors;
		int            n_checked;
		int            n_oor;

		function void note_input(input logic [63:0] base, input logic signed [7:0] pw);
			pending.push_back(predict_power(base, pw));
		endfunction

		function void check_result(input logic [63:0] res, input logic oor);
			power_result_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h oor %b", $time, res, oor);
				errors++;
				return;
			end
			e = pending.pop_front();
			n_checked++;
			if (oor) n_oor++;
			if (res !== e.result_bits) begin
				$display("%0t: result_bits expected %h actual %h", $time,
					e.result_bits, res);
				errors++;
			end
			if (oor !== e.overrange) begin
				$display("%0t: overrange expected %b actual %b", $time,
					e.overrange, oor);
				errors++;
			end
		endfunction
	endclass

	power_scoreboard sb;
	bit  steady;       // no idling on either side
	bit  hold_out;     // long output stall requested
	int  quiet_cycles;

	double_integer_power_chain u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// accept monitors and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_input(s_tdata[63:0], s_tdata[71:64]);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tuser);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WDOG_MAX) begin
				$display("%0t: watchdog expired", $time);
				$display("FAIL");
				$finish;
			end
		end
	end

	// output side: random stalls, one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_out) begin
				m_tready <= 1'b0;
				repeat (HOLD_OFF) @(negedge clk);
				hold_out = 1'b0;
			end
			m_tready <= steady || ($urandom_range(99) >= 21);
		end
	end

	task automatic send_item(input logic [63:0] base, input logic [7:0] pw);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 21) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {pw, base};
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic logic [63:0] pick_base();
		logic [63:0] b;
		b = {$urandom, $urandom};
		case ($urandom_range(9))
			0, 1: ;                                            // any pattern
			2: b[62:52] = 11'($urandom_range(1023 + 300, 1023 - 300));
			3: b[62:52] = '0;                                  // subnormal or zero
			4: begin b[62:52] = '1; if ($urandom_range(1)) b[51:0] = '0; end
			5: b[51:0] = 52'($urandom_range(7)) << 49;       // exact-ish values
			default: b[62:52] = 11'($urandom_range(1023 + 24, 1023 - 24));
		endcase
		return b;
	endfunction

	function automatic logic [7:0] pick_power();
		if ($urandom_range(9) == 0)
			return 8'($urandom);
		return 8'($urandom_range(80) - 40);
	endfunction

	initial begin
		logic [63:0] dir_base[$];
		logic [7:0]  dir_pow[$];
		int          wait_cycles;
		sb       = new();
		steady   = 1'b0;
		hold_out = 1'b0;
		quiet_cycles = 0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		arst_n   = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: special bases, zero and out-of-range powers, extremes
		dir_base = '{64'h7FF8_0000_0000_0001, 64'hFFF0_0000_0000_0000, 64'h0,
			64'h0, 64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000,
			64'h4000_0000_0000_0000, 64'h4000_0000_0000_0000, 64'h4000_0000_0000_0000,
			64'h3FF8_0000_0000_0000, 64'h0000_0000_0000_0001, 64'h000F_FFFF_FFFF_FFFF,
			64'h7FEF_FFFF_FFFF_FFFF, 64'hBFF0_0000_0000_0001, 64'h7FF0_0000_0000_0000,
			64'hFFFF_FFFF_FFFF_FFFF, 64'h3FEF_FFFF_FFFF_FFFF, 64'h0010_0000_0000_0000,
			64'hC008_0000_0000_0000, 64'h3FF0_0000_0000_0000};
		dir_pow = '{8'd0, 8'd0, 8'd0, 8'hFF, 8'hFD, 8'h80, 8'd127, 8'd41, 8'hD7,
			8'd40, 8'hD8, 8'd1, 8'd2, 8'd39, 8'hFE, 8'd5, 8'd23, 8'hFF, 8'd35, 8'd29};
		foreach (dir_base[i])
			send_item(dir_base[i], dir_pow[i]);

		for (int i = 0; i < N_RANDOM; i++) begin
			steady = (i >= 300 && i < 500);
			if (i == 800) hold_out = 1'b1;
			send_item(pick_base(), pick_power());
		end
		@(negedge clk);
		s_tvalid <= 1'b0;
		steady = 1'b0;

		wait_cycles = 0;
		while (sb.pending.size() != 0 && wait_cycles < 200000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (200) @(posedge clk);
		$display("Checked %0d results (%0d out of range) over %0d random",
			sb.n_checked, sb.n_oor, N_RANDOM);
		$display("and %0d directed items, with idle, steady and long-stall phases.",
			dir_base.size());
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("PASS");
		end else begin
			$display("%0d errors, %0d results missing", sb.errors, sb.pending.size());
			$display("FAIL");
		end
		$finish;
	end

endmodule
